// ===== rtl/core/assert_macros.svh =====
// assertion macros shared by the list rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, idle during reset
`define ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, idle during reset
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/core/pidl_pkg.sv =====
// types and constants of the positional insert/delete list
`default_nettype none

package pidl_pkg;

    localparam int DEPTH   = 128;
    localparam int ELEM_W  = 32;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int POS_W   = 8;
    localparam int VAL_W   = 32;
    localparam int TOTAL_W = 8;
    localparam int CMP_W   = ((POS_W > CNT_W) ? POS_W : CNT_W) + 1;

    typedef enum logic [1:0] {
        ACT_APPEND = 2'd0,
        ACT_INSERT = 2'd1,
        ACT_DELETE = 2'd2,
        ACT_READ   = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_BAD_POS = 2'd1,
        ST_FULL    = 2'd2,
        ST_EMPTY   = 2'd3
    } status_t;

    typedef struct packed {
        status_t              status;
        logic [VAL_W-1:0]     read_value;
        logic [TOTAL_W-1:0]   entry_total;
    } result_t;

endpackage

`default_nettype wire

// ===== rtl/core/pidl_ram.sv =====
// simple dual-port ram, one write and one registered read per cycle
`default_nettype none

module pidl_ram #(
    parameter int DEPTH_P = 128,
    parameter int WIDTH_P = 32,
    parameter int AW_P    = $clog2(DEPTH_P)
) (
    input  wire logic               clk,
    input  wire logic               we,
    input  wire logic [AW_P-1:0]    waddr,
    input  wire logic [WIDTH_P-1:0] wdata,
    input  wire logic               re,
    input  wire logic [AW_P-1:0]    raddr,
    output logic      [WIDTH_P-1:0] rdata
);

    logic [WIDTH_P-1:0] mem [DEPTH_P];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/pidl_ctrl.sv =====
// sequencer: checks each action and walks the element memory to shift entries
`default_nettype none
`include "assert_macros.svh"

module pidl_ctrl
    import pidl_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire action_t           in_action,
    input  wire logic [POS_W-1:0]  in_pos,
    input  wire logic [VAL_W-1:0]  in_value,
    output logic                   res_valid,
    input  wire logic              res_ready,
    output result_t                res,
    output logic                   ram_we,
    output logic [ADDR_W-1:0]      ram_waddr,
    output logic [ELEM_W-1:0]      ram_wdata,
    output logic                   ram_re,
    output logic [ADDR_W-1:0]      ram_raddr,
    input  wire logic [ELEM_W-1:0] ram_rdata
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD_WAIT,
        S_INS_RD,
        S_INS_WR,
        S_DEL_RD,
        S_DEL_WR,
        S_RESP
    } state_t;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [ADDR_W-1:0]  cur_reg, cur_next;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic [ELEM_W-1:0]  val_reg, val_next;
    status_t            status_reg, status_next;
    logic [VAL_W-1:0]   rd_reg, rd_next;

    logic [CMP_W-1:0]   cnt_x;
    logic [CMP_W-1:0]   pos_x;
    logic [CMP_W-1:0]   pos_m1;
    logic [ELEM_W-1:0]  val_ext;
    status_t            st_now;

    assign cnt_x   = CMP_W'(cnt_reg);
    assign pos_x   = CMP_W'(in_pos);
    assign pos_m1  = pos_x - CMP_W'(1);
    assign val_ext = ELEM_W'($signed(in_value));

    // error checks on the incoming action against the current count
    always_comb
    begin
        st_now = ST_OK;
        case (in_action)
            ACT_APPEND:
            begin
                if (cnt_x == CMP_W'(DEPTH))
                    st_now = ST_FULL;
            end
            ACT_INSERT:
            begin
                if (pos_x == '0 || pos_x > cnt_x + CMP_W'(1))
                    st_now = ST_BAD_POS;
                else if (cnt_x == CMP_W'(DEPTH))
                    st_now = ST_FULL;
            end
            ACT_DELETE, ACT_READ:
            begin
                if (cnt_x == '0)
                    st_now = ST_EMPTY;
                else if (pos_x == '0 || pos_x > cnt_x)
                    st_now = ST_BAD_POS;
            end
            default:
            begin
                st_now = ST_OK;
            end
        endcase
    end

    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        cur_next    = cur_reg;
        pos_next    = pos_reg;
        val_next    = val_reg;
        status_next = status_reg;
        rd_next     = rd_reg;
        ram_we      = 1'b0;
        ram_waddr   = cur_reg;
        ram_wdata   = ram_rdata;
        ram_re      = 1'b0;
        ram_raddr   = cur_reg;
        in_ready    = 1'b0;
        res_valid   = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    pos_next    = in_pos;
                    val_next    = val_ext;
                    status_next = st_now;
                    rd_next     = '0;
                    if (st_now != ST_OK)
                    begin
                        state_next = S_RESP;
                    end
                    else
                    begin
                        case (in_action)
                            ACT_APPEND:
                            begin
                                ram_we     = 1'b1;
                                ram_waddr  = cnt_reg[ADDR_W-1:0];
                                ram_wdata  = val_ext;
                                cnt_next   = cnt_reg + CNT_W'(1);
                                state_next = S_RESP;
                            end
                            ACT_INSERT:
                            begin
                                cur_next   = cnt_reg[ADDR_W-1:0];
                                state_next = S_INS_RD;
                            end
                            ACT_DELETE:
                            begin
                                cur_next   = pos_m1[ADDR_W-1:0];
                                state_next = S_DEL_RD;
                            end
                            ACT_READ:
                            begin
                                ram_re     = 1'b1;
                                ram_raddr  = pos_m1[ADDR_W-1:0];
                                state_next = S_RD_WAIT;
                            end
                            default:
                            begin
                                state_next = S_RESP;
                            end
                        endcase
                    end
                end
            end
            S_RD_WAIT:
            begin
                rd_next    = VAL_W'(ram_rdata);
                state_next = S_RESP;
            end
            S_INS_RD:
            begin
                // reached the insert slot: drop the new value in
                if (CMP_W'(cur_reg) + CMP_W'(1) == CMP_W'(pos_reg))
                begin
                    ram_we     = 1'b1;
                    ram_waddr  = cur_reg;
                    ram_wdata  = val_reg;
                    cnt_next   = cnt_reg + CNT_W'(1);
                    state_next = S_RESP;
                end
                else
                begin
                    ram_re     = 1'b1;
                    ram_raddr  = cur_reg - ADDR_W'(1);
                    state_next = S_INS_WR;
                end
            end
            S_INS_WR:
            begin
                ram_we     = 1'b1;
                ram_waddr  = cur_reg;
                ram_wdata  = ram_rdata;
                cur_next   = cur_reg - ADDR_W'(1);
                state_next = S_INS_RD;
            end
            S_DEL_RD:
            begin
                // last live entry reached: shrink the list
                if (CMP_W'(cur_reg) + CMP_W'(1) == cnt_x)
                begin
                    cnt_next   = cnt_reg - CNT_W'(1);
                    state_next = S_RESP;
                end
                else
                begin
                    ram_re     = 1'b1;
                    ram_raddr  = cur_reg + ADDR_W'(1);
                    state_next = S_DEL_WR;
                end
            end
            S_DEL_WR:
            begin
                ram_we     = 1'b1;
                ram_waddr  = cur_reg;
                ram_wdata  = ram_rdata;
                cur_next   = cur_reg + ADDR_W'(1);
                state_next = S_DEL_RD;
            end
            S_RESP:
            begin
                res_valid = 1'b1;
                if (res_ready)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            cnt_reg    <= '0;
            cur_reg    <= '0;
            pos_reg    <= '0;
            val_reg    <= '0;
            status_reg <= ST_OK;
            rd_reg     <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            cur_reg    <= cur_next;
            pos_reg    <= pos_next;
            val_reg    <= val_next;
            status_reg <= status_next;
            rd_reg     <= rd_next;
        end
    end

    assign res.status      = status_reg;
    assign res.read_value  = rd_reg;
    assign res.entry_total = TOTAL_W'(cnt_reg);

    `ASSERT_IMPL(a_cnt_range, 1'b1, cnt_reg <= CNT_W'(DEPTH))
    `ASSERT_NEXT(a_err_keeps_cnt, in_valid && in_ready && st_now != ST_OK, cnt_reg == $past(cnt_reg))
    `ASSERT_IMPL(a_del_read_live, ram_re && state_reg == S_DEL_RD, CNT_W'(ram_raddr) < cnt_reg)
    `ASSERT_IMPL(a_shift_write_bound, ram_we && state_reg != S_IDLE, CNT_W'(ram_waddr) <= cnt_reg)

endmodule

`default_nettype wire

// ===== rtl/core/positional_insert_delete_list_top.sv =====
// top level of the positional insert/delete list: stream ports and result register
//
//  channel   dir   tdata (low bit up)                  tuser
//  s_axis    in    position[7:0], value[31:0]          action[1:0]
//  m_axis    out   read_value[31:0], entry_total[7:0]  status[1:0]
//
//  one item at a time; the element memory does one read or one write per cycle
//  append and any error go straight to the result; read waits on the registered ram read
//  with n entries, insert at p shifts p..n up and delete shifts p+1..n down
//  the result register lets the next item start while a result waits
//  reset clears the count; memory contents need no clearing
`default_nettype none

module positional_insert_delete_list_top
    import pidl_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [39:0] s_axis_tdata,   // position[7:0], value[39:8]
    input  wire logic [1:0]  s_axis_tuser,   // action[1:0]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [39:0]      m_axis_tdata,   // read_value[31:0], entry_total[39:32]
    output logic [1:0]       m_axis_tuser    // status[1:0]
);

    logic               res_valid;
    logic               res_ready;
    result_t            res;
    logic               ram_we;
    logic [ADDR_W-1:0]  ram_waddr;
    logic [ELEM_W-1:0]  ram_wdata;
    logic               ram_re;
    logic [ADDR_W-1:0]  ram_raddr;
    logic [ELEM_W-1:0]  ram_rdata;

    logic               out_valid_reg, out_valid_next;
    result_t            out_res_reg, out_res_next;

    pidl_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_action (action_t'(s_axis_tuser)),
        .in_pos    (s_axis_tdata[POS_W-1:0]),
        .in_value  (s_axis_tdata[POS_W+VAL_W-1:POS_W]),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

    pidl_ram #(
        .DEPTH_P (DEPTH),
        .WIDTH_P (ELEM_W)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // result register takes a new result when empty or being drained
    assign res_ready = !out_valid_reg || m_axis_tready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_res_next   = out_res_reg;
        if (res_ready)
        begin
            out_valid_next = res_valid;
            if (res_valid)
                out_res_next = res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_res_reg <= out_res_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_res_reg.entry_total, out_res_reg.read_value};
    assign m_axis_tuser  = out_res_reg.status;

endmodule

`default_nettype wire

// ===== bench/positional_insert_delete_list_top_tb.sv =====
// self-checking testbench for the positional insert/delete list top level
module positional_insert_delete_list_top_tb;

    import pidl_pkg::*;

    localparam int RANDOM_ITEMS = 1030;
    localparam int STALL_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 300;

    typedef enum int { DRIFT_GROW, DRIFT_SHRINK, DRIFT_MIXED } drift_t;

    // shadow copy of the list plus the results it predicts, oldest first
    class list_shadow;
        logic [ELEM_W-1:0] cells [DEPTH];
        int unsigned       held;
        result_t           pending [$];
        int unsigned       errors;

        function new();
            held   = 0;
            errors = 0;
        endfunction

        function void accept_command(action_t act, logic [POS_W-1:0] pos,
                                     logic [VAL_W-1:0] val);
            result_t want;
            int      p;
            int      i;
            p               = pos;
            want.status     = ST_OK;
            want.read_value = '0;
            case (act)
                ACT_APPEND:
                begin
                    if (held >= DEPTH)
                        want.status = ST_FULL;
                    else
                    begin
                        cells[held] = ELEM_W'($signed(val));
                        held++;
                    end
                end
                ACT_INSERT:
                begin
                    // position is checked before capacity
                    if (p == 0 || p > held + 1)
                        want.status = ST_BAD_POS;
                    else if (held >= DEPTH)
                        want.status = ST_FULL;
                    else
                    begin
                        for (i = held; i >= p; i--)
                            cells[i] = cells[i-1];
                        cells[p-1] = ELEM_W'($signed(val));
                        held++;
                    end
                end
                ACT_DELETE:
                begin
                    if (held == 0)
                        want.status = ST_EMPTY;
                    else if (p == 0 || p > held)
                        want.status = ST_BAD_POS;
                    else
                    begin
                        for (i = p - 1; i + 1 < held; i++)
                            cells[i] = cells[i+1];
                        held--;
                    end
                end
                default:
                begin
                    if (held == 0)
                        want.status = ST_EMPTY;
                    else if (p == 0 || p > held)
                        want.status = ST_BAD_POS;
                    else
                        want.read_value = VAL_W'(cells[p-1]);
                end
            endcase
            want.entry_total = TOTAL_W'(held);
            pending.push_back(want);
        endfunction

        function void check_response(status_t st, logic [VAL_W-1:0] rd,
                                     logic [TOTAL_W-1:0] total);
            result_t want;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected result status %0d read_value %h entry_total %0d",
                         $time, st, rd, total);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (st !== want.status)
            begin
                $display("%0t: status expected %0d actual %0d", $time, want.status, st);
                errors++;
            end
            if (rd !== want.read_value)
            begin
                $display("%0t: read_value expected %h actual %h",
                         $time, want.read_value, rd);
                errors++;
            end
            if (total !== want.entry_total)
            begin
                $display("%0t: entry_total expected %0d actual %0d",
                         $time, want.entry_total, total);
                errors++;
            end
        endfunction
    endclass

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata  = '0;   // position[7:0], value[39:8]
    logic [1:0]  s_axis_tuser  = ACT_APPEND;   // action[1:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;         // read_value[31:0], entry_total[39:32]
    logic [1:0]  m_axis_tuser;         // status[1:0]

    list_shadow  shadow = new();
    int          burst_left = 0;
    int          idle_cycles = 0;
    logic [31:0] corner_values [4] = '{32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'hffff_ffff};

    positional_insert_delete_list_top u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // called at a falling edge, returns at the falling edge after the transfer
    task automatic send_command(input action_t act, input logic [POS_W-1:0] pos,
                                input logic [VAL_W-1:0] val);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                s_axis_tvalid = 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = act;
        s_axis_tdata  = {val, pos};
        do
            @(posedge clk);
        while (!s_axis_tready);
        @(negedge clk);
    endtask

    // transfer tracking and watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
                shadow.accept_command(action_t'(s_axis_tuser), s_axis_tdata[7:0],
                                      s_axis_tdata[39:8]);
            if (m_axis_tvalid && m_axis_tready)
                shadow.check_response(status_t'(m_axis_tuser), m_axis_tdata[31:0],
                                      m_axis_tdata[39:32]);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // receiver stalls in stretches of differing character
    initial
    begin
        int style;
        int hold;
        hold = 0;
        wait (rst_n);
        forever
        begin
            style = $urandom_range(0, 3);
            repeat ($urandom_range(20, 200))
            begin
                @(negedge clk);
                case (style)
                    0: m_axis_tready = 1'b1;
                    1: m_axis_tready = $urandom_range(0, 1);
                    2: m_axis_tready = ($urandom_range(0, 4) == 0);
                    default:
                    begin
                        if (hold == 0)
                        begin
                            m_axis_tready = !m_axis_tready;
                            hold = $urandom_range(1, 40);
                        end
                        hold--;
                    end
                endcase
            end
        end
    end

    initial
    begin
        drift_t           drift;
        action_t          act;
        logic [POS_W-1:0] pos;
        logic [VAL_W-1:0] value;
        int               held;
        int               dwell;
        int               r;
        int               n;

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // empty list, bad positions, front, end and middle inserts, then reads and deletes
        send_command(ACT_READ,   8'd1,   32'h5a5a_5a5a);
        send_command(ACT_DELETE, 8'd0,   32'h0);
        send_command(ACT_INSERT, 8'd0,   32'd5);
        send_command(ACT_INSERT, 8'd2,   32'd5);
        send_command(ACT_INSERT, 8'd1,   32'h7fff_ffff);
        send_command(ACT_APPEND, 8'hff,  32'h8000_0000);
        send_command(ACT_APPEND, 8'd0,   32'h0);
        send_command(ACT_APPEND, 8'd0,   32'hffff_ffff);
        send_command(ACT_INSERT, 8'd1,   32'h1234_5678);
        send_command(ACT_INSERT, 8'd6,   32'ha5a5_a5a5);
        send_command(ACT_INSERT, 8'd3,   32'd1);
        send_command(ACT_INSERT, 8'd9,   32'd2);
        send_command(ACT_READ,   8'd0,   32'hffff_ffff);
        send_command(ACT_READ,   8'd8,   32'h0);
        send_command(ACT_READ,   8'hff,  32'h0);
        send_command(ACT_READ,   8'd1,   32'h0);
        send_command(ACT_READ,   8'd7,   32'h0);
        send_command(ACT_READ,   8'd4,   32'h0);
        send_command(ACT_DELETE, 8'd8,   32'h0);
        send_command(ACT_DELETE, 8'd1,   32'h0);
        send_command(ACT_DELETE, 8'd6,   32'h0);
        send_command(ACT_DELETE, 8'd3,   32'h0);
        send_command(ACT_READ,   8'd3,   32'h0);

        // fill to full, linger there, drain to empty, wander, repeat
        drift = DRIFT_GROW;
        dwell = 0;
        for (n = 0; n < RANDOM_ITEMS; n++)
        begin
            held = shadow.held;
            case (drift)
                DRIFT_GROW:
                    if (held == DEPTH)
                    begin
                        dwell++;
                        if (dwell > 15)
                        begin
                            drift = DRIFT_SHRINK;
                            dwell = 0;
                        end
                    end
                DRIFT_SHRINK:
                    if (held == 0)
                    begin
                        dwell++;
                        if (dwell > 6)
                        begin
                            drift = DRIFT_MIXED;
                            dwell = 0;
                        end
                    end
                default:
                begin
                    dwell++;
                    if (dwell > 80)
                    begin
                        drift = DRIFT_GROW;
                        dwell = 0;
                    end
                end
            endcase

            r = $urandom_range(0, 99);
            case (drift)
                DRIFT_GROW:
                    act = (r < 50) ? ACT_APPEND : (r < 80) ? ACT_INSERT :
                          (r < 92) ? ACT_READ : ACT_DELETE;
                DRIFT_SHRINK:
                    act = (r < 5) ? ACT_APPEND : (r < 15) ? ACT_INSERT :
                          (r < 85) ? ACT_DELETE : ACT_READ;
                default:
                    act = action_t'(r % 4);
            endcase

            r = $urandom_range(0, 99);
            if (r < 80)
                pos = (act == ACT_INSERT) ? POS_W'($urandom_range(1, held + 1)) :
                      POS_W'($urandom_range(1, (held > 0) ? held : 1));
            else if (r < 88)
                pos = (act == ACT_INSERT) ? POS_W'(held + 2) : POS_W'(held + 1);
            else if (r < 92)
                pos = '0;
            else
                pos = POS_W'($urandom_range(0, 255));

            value = ($urandom_range(0, 9) == 0) ? corner_values[$urandom_range(0, 3)] :
                    $urandom();
            send_command(act, pos, value);
        end

        s_axis_tvalid = 1'b0;
        while (shadow.pending.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (shadow.pending.size() != 0)
        begin
            $display("%0t: %0d expected results never arrived", $time,
                     shadow.pending.size());
            shadow.errors++;
        end
        if (shadow.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
